/* sv/hts_pkg.sv */
// ----------------------------------------------------------------------------
// hts_pkg
// Shared constants and types for the height-grid triangle sampler.
// ----------------------------------------------------------------------------
package hts_pkg;

   localparam int MAX_GRID_SIDE = 256;
   localparam int ADDR_W = 16;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int REG_W = 32;
   localparam int SIDE_W = 9;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] MODE_LOAD_HEIGHT = 2'd0;
   localparam logic [1:0] MODE_LOAD_FLAGS = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_Y = 3'd5;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // per-axis mapping result
   typedef struct packed {
      logic       ok;
      logic [7:0] cell_idx;
      logic [16:0] frac;
   } axis_type;

endpackage

/* sv/hts_axis_map.sv */
// ----------------------------------------------------------------------------
// hts_axis_map
// Three-stage mapping of one query coordinate onto the grid: subtract origin,
// scale by reciprocal spacing (two 16x32 partial products), bound and split.
// ----------------------------------------------------------------------------
module hts_axis_map
   import hts_pkg::*;
#(
   parameter int SIDE_W_P = 9
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [31:0]  q,
   input  logic signed [31:0]  org,
   input  logic [31:0]         inv,
   input  logic [SIDE_W_P-1:0] side,
   output axis_type            axis_out
);

   logic signed [32:0] d_in;
   logic [31:0] d_ff;
   logic [47:0] phi_ff;
   logic [47:0] plo_ff;
   logic        neg_ff;
   logic [48:0] g;
   logic [48:0] lim;
   logic [48:0] c;
   logic [48:0] f;
   logic [48:0] cmax;
   axis_type    res_ff;

   assign d_in = 33'(q) - 33'(org);

   // stage A: difference; stage B: partial products; stage C: bound and split
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff   <= d_in[31:0];
         neg_ff <= d_in[32];
         phi_ff <= 48'({d_ff[31:16]}) * 48'(inv);
         plo_ff <= (48'({d_ff[15:0]}) * 48'(inv)) >> 16;
      end
   end

   logic neg_b_ff;
   always_ff @(posedge clock) begin
      if (en) neg_b_ff <= neg_ff;
   end

   always_comb begin
      g    = 49'(phi_ff) + 49'(plo_ff);
      lim  = 49'(side - SIDE_W_P'(1)) << 24;
      cmax = 49'(side - SIDE_W_P'(2));
      c    = g >> 24;
      if (c > cmax) c = cmax;
      f = (g - (c << 24)) >> 8;
      if (f > 49'(ONE_Q16)) f = 49'(ONE_Q16);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.ok       <= !neg_b_ff && (g <= lim);
         res_ff.cell_idx <= c[7:0];
         res_ff.frac     <= f[16:0];
      end
   end

   assign axis_out = res_ff;

endmodule

/* sv/heightfield_triangle_sampler_unit.sv */
// ----------------------------------------------------------------------------
// heightfield_triangle_sampler_unit
// Loads and samples a triangulated height grid held in on-chip memories.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is free or being emptied, so a stalled result holds everything.
// Reset: synchronous, clears valid bits and loads config registers with their
// defaults; the height and flag memories are not cleared. Entries must be
// written before they are read; the block itself does not enforce this.
// Stages: 1-3 axis mapping, 4 address calc, 5 flag read, 6 height read,
// 7 differences, 8 products, 9 sum/saturate into the output register.
// Loads ride the pipe and write flags at stage 4 and heights at stage 5, so
// every query sees exactly the loads accepted ahead of it.
module heightfield_triangle_sampler_unit
   import hts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // tdata: mode[1:0], sample_index[17:2], height_value[49:18], cell_index[65:50],
   // cell_uncovered[66], cell_diagonal[67], query_x[99:68], query_y[131:100]
   input  logic [135:0]         req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // tdata: hit[0], height_out[32:1]
   output logic [39:0]          rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   logic [SIDE_W-1:0] grid_w_ff, grid_h_ff;
   logic [31:0] org_x_ff, org_y_ff, inv_x_ff, inv_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= SIDE_W'(2);
         grid_h_ff <= SIDE_W'(2);
         org_x_ff  <= '0;
         org_y_ff  <= '0;
         inv_x_ff  <= 32'h0100_0000;
         inv_y_ff  <= 32'h0100_0000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_w_ff <= csr_wdata[SIDE_W-1:0];
            CSR_GRID_HEIGHT: grid_h_ff <= csr_wdata[SIDE_W-1:0];
            CSR_ORIGIN_X:    org_x_ff <= csr_wdata;
            CSR_ORIGIN_Y:    org_y_ff <= csr_wdata;
            CSR_INV_X:       inv_x_ff <= csr_wdata;
            CSR_INV_Y:       inv_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective sides
   logic [SIDE_W-1:0] w_eff, h_eff;
   logic small_grid;
   assign w_eff = (grid_w_ff > SIDE_W'(MAX_GRID_SIDE)) ? SIDE_W'(MAX_GRID_SIDE) : grid_w_ff;
   assign h_eff = (grid_h_ff > SIDE_W'(MAX_GRID_SIDE)) ? SIDE_W'(MAX_GRID_SIDE) : grid_h_ff;
   assign small_grid = (w_eff < SIDE_W'(2)) || (h_eff < SIDE_W'(2));

   // pipeline advance
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic [1:0]  mode;
   logic [15:0] s_idx, c_idx;
   logic [31:0] hval;
   logic        unc_in, dia_in;
   assign mode   = req_tdata[1:0];
   assign s_idx  = req_tdata[17:2];
   assign hval   = req_tdata[49:18];
   assign c_idx  = req_tdata[65:50];
   assign unc_in = req_tdata[66];
   assign dia_in = req_tdata[67];

   logic acc;
   assign acc = req_tvalid && req_tready;

   // load items travel with the pipe; slot i holds stage i+1
   logic [4:0]  ldh_ff;
   logic [3:0]  ldf_ff;
   logic [15:0] lda_ff [5];
   logic [31:0] ldd_ff [5];
   always_ff @(posedge clock) begin
      if (reset) begin
         ldh_ff <= '0;
         ldf_ff <= '0;
      end else if (adv) begin
         ldh_ff <= {ldh_ff[3:0], acc && mode == MODE_LOAD_HEIGHT};
         ldf_ff <= {ldf_ff[2:0], acc && mode == MODE_LOAD_FLAGS};
      end
      if (adv) begin
         lda_ff[0] <= (mode == MODE_LOAD_HEIGHT) ? s_idx : c_idx;
         ldd_ff[0] <= (mode == MODE_LOAD_HEIGHT) ? hval : {30'd0, dia_in, unc_in};
         for (int i = 1; i < 5; i++) begin
            lda_ff[i] <= lda_ff[i-1];
            ldd_ff[i] <= ldd_ff[i-1];
         end
      end
   end

   // memories; heights kept twice so each copy serves two corner reads
   logic [31:0] hmem_a [STORE_DEPTH];
   logic [31:0] hmem_b [STORE_DEPTH];
   logic [1:0]  fmem [STORE_DEPTH];
   always_ff @(posedge clock) begin
      if (adv && ldf_ff[3]) fmem[lda_ff[3]] <= ldd_ff[3][1:0];
      if (adv && ldh_ff[4]) begin
         hmem_a[lda_ff[4]] <= ldd_ff[4];
         hmem_b[lda_ff[4]] <= ldd_ff[4];
      end
   end

   // valid chain for the query stages 1..3
   logic [2:0] qv_ff;
   logic [2:0] sg_ff;
   always_ff @(posedge clock) begin
      if (reset) qv_ff <= '0;
      else if (adv) qv_ff <= {qv_ff[1:0], acc && mode == MODE_QUERY};
      if (adv) sg_ff <= {sg_ff[1:0], small_grid};
   end

   axis_type ax, ay;
   hts_axis_map #(.SIDE_W_P(SIDE_W)) u_map_x (
      .clock(clock), .en(adv), .q(req_tdata[99:68]), .org(org_x_ff),
      .inv(inv_x_ff), .side(w_eff), .axis_out(ax));
   hts_axis_map #(.SIDE_W_P(SIDE_W)) u_map_y (
      .clock(clock), .en(adv), .q(req_tdata[131:100]), .org(org_y_ff),
      .inv(inv_y_ff), .side(h_eff), .axis_out(ay));

   // stage 4: addresses
   logic v4_ff, ok4_ff;
   logic [15:0] cell4_ff, row4_ff, w4_ff;
   logic [16:0] fx4_ff, fy4_ff;
   logic [16:0] cellp, rowp;
   assign cellp = 17'(ay.cell_idx) * 17'(w_eff - SIDE_W'(1)) + 17'(ax.cell_idx);
   assign rowp  = 17'(ay.cell_idx) * 17'(w_eff) + 17'(ax.cell_idx);
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= qv_ff[2];
      if (adv) begin
         ok4_ff   <= ax.ok && ay.ok && !sg_ff[2];
         cell4_ff <= cellp[15:0];
         row4_ff  <= rowp[15:0];
         w4_ff    <= 16'(w_eff);
         fx4_ff   <= ax.frac;
         fy4_ff   <= ay.frac;
      end
   end

   // stage 5: flag read
   logic v5_ff, ok5_ff;
   logic [1:0] fl5_ff;
   logic [15:0] row5_ff, w5_ff;
   logic [16:0] fx5_ff, fy5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         fl5_ff  <= fmem[cell4_ff];
         ok5_ff  <= ok4_ff;
         row5_ff <= row4_ff;
         w5_ff   <= w4_ff;
         fx5_ff  <= fx4_ff;
         fy5_ff  <= fy4_ff;
      end
   end

   // stage 6: height reads (two corners from each copy)
   logic v6_ff, ok6_ff, dg6_ff;
   logic [31:0] z00_ff, z10_ff, z01_ff, z11_ff;
   logic [16:0] fx6_ff, fy6_ff;
   logic [15:0] a10, a01, a11;
   assign a10 = row5_ff + 16'd1;
   assign a01 = row5_ff + w5_ff;
   assign a11 = row5_ff + w5_ff + 16'd1;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         z00_ff <= hmem_a[row5_ff];
         z10_ff <= hmem_a[a10];
         z01_ff <= hmem_b[a01];
         z11_ff <= hmem_b[a11];
         ok6_ff <= ok5_ff && !fl5_ff[0];
         dg6_ff <= fl5_ff[1];
         fx6_ff <= fx5_ff;
         fy6_ff <= fy5_ff;
      end
   end

   // stage 7: triangle select and differences
   logic v7_ff, ok7_ff;
   logic signed [32:0] base7_ff, da7_ff, db7_ff;
   logic [16:0] ka7_ff, kb7_ff;
   logic signed [32:0] s00, s10, s01, s11;
   logic [17:0] fsum;
   assign s00 = 33'(signed'(z00_ff));
   assign s10 = 33'(signed'(z10_ff));
   assign s01 = 33'(signed'(z01_ff));
   assign s11 = 33'(signed'(z11_ff));
   assign fsum = 18'(fx6_ff) + 18'(fy6_ff);
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
      if (adv) begin
         ok7_ff <= ok6_ff;
         base7_ff <= s00;
         ka7_ff <= fx6_ff;
         kb7_ff <= fy6_ff;
         if (!dg6_ff) begin
            if (fy6_ff <= fx6_ff) begin
               da7_ff <= s10 - s00; db7_ff <= s11 - s10;
            end else begin
               da7_ff <= s11 - s01; db7_ff <= s01 - s00;
            end
         end else if (fsum <= 18'(ONE_Q16)) begin
            da7_ff <= s10 - s00; db7_ff <= s01 - s00;
         end else begin
            base7_ff <= s11;
            ka7_ff <= ONE_Q16 - fy6_ff; da7_ff <= s10 - s11;
            kb7_ff <= ONE_Q16 - fx6_ff; db7_ff <= s01 - s11;
         end
      end
   end

   // stage 8: products, floor shift
   logic v8_ff, ok8_ff;
   logic signed [32:0] base8_ff;
   logic signed [50:0] pa8_ff, pb8_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
      if (adv) begin
         ok8_ff   <= ok7_ff;
         base8_ff <= base7_ff;
         pa8_ff   <= (51'(signed'({1'b0, ka7_ff})) * 51'(da7_ff)) >>> 16;
         pb8_ff   <= (51'(signed'({1'b0, kb7_ff})) * 51'(db7_ff)) >>> 16;
      end
   end

   // stage 9: sum, saturate, output register
   logic signed [36:0] sum;
   logic [31:0] hsat;
   assign sum = 37'(base8_ff) + 37'(pa8_ff) + 37'(pb8_ff);
   always_comb begin
      if (sum > 37'sd2147483647) hsat = 32'h7FFF_FFFF;
      else if (sum < -37'sd2147483648) hsat = 32'h8000_0000;
      else hsat = sum[31:0];
   end

   logic hit_ff;
   logic [31:0] hout_ff;
   logic ov_ff;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (adv) ov_ff <= v8_ff;
      if (adv) begin
         hit_ff  <= ok8_ff;
         hout_ff <= ok8_ff ? hsat : 32'd0;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {7'd0, hout_ff, hit_ff};

   // a held result must not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // a miss always reports zero height
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("miss with nonzero height");
   // no item taken while the output is stuck
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("accept during stall");

endmodule
